@@ src/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpd_pkg
// shared types, constants and decode functions for the keypad scanner
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int unsigned RowWidth    = 4;
    localparam int unsigned ColWidth    = 3;
    localparam int unsigned CharWidth   = 7;
    localparam int unsigned CountWidth  = 8;
    localparam int unsigned InBytes     = 1;
    localparam int unsigned OutBytes    = 2;

    localparam logic [RowWidth-1:0]   RowCode0     = 4'he;
    localparam logic [RowWidth-1:0]   RowCode1     = 4'hd;
    localparam logic [RowWidth-1:0]   RowCode2     = 4'hb;
    localparam logic [RowWidth-1:0]   RowCode3     = 4'h7;
    localparam logic [ColWidth-1:0]   AllColumns   = 3'b111;
    localparam logic [ColWidth-1:0]   Column0      = 3'b001;
    localparam logic [ColWidth-1:0]   Column1      = 3'b010;
    localparam logic [ColWidth-1:0]   Column2      = 3'b100;
    localparam logic [CountWidth-1:0] DebounceInit = 8'd100;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_DEBOUNCE = 3'd1,
        ST_CHECK0   = 3'd2,
        ST_CHECK1   = 3'd3,
        ST_CHECK2   = 3'd4,
        ST_RELEASE  = 3'd5
    } kpd_state_t;

    // packed so that key_valid sits in bit 0 of the result word
    typedef struct packed {
        logic [ColWidth-1:0]  column_drive;
        logic [CharWidth-1:0] key_char;
        logic                 key_valid;
    } kpd_result_t;

    typedef struct packed {
        logic          pressed;
        logic [1:0]    row;
    } kpd_row_t;

    // exactly one row low counts as a press
    function automatic kpd_row_t decode_row(input logic [RowWidth-1:0] pins);
        kpd_row_t r;
        r.pressed = 1'b1;
        r.row     = 2'd0;
        case (pins)
            RowCode0: r.row = 2'd0;
            RowCode1: r.row = 2'd1;
            RowCode2: r.row = 2'd2;
            RowCode3: r.row = 2'd3;
            default:  r.pressed = 1'b0;
        endcase
        return r;
    endfunction

    // key map "#9630852*741", index 4*column+row
    function automatic logic [CharWidth-1:0] key_lookup(input logic [3:0] idx);
        logic [CharWidth-1:0] c;
        case (idx)
            4'd0:    c = 7'h23;
            4'd1:    c = 7'h39;
            4'd2:    c = 7'h36;
            4'd3:    c = 7'h33;
            4'd4:    c = 7'h30;
            4'd5:    c = 7'h38;
            4'd6:    c = 7'h35;
            4'd7:    c = 7'h32;
            4'd8:    c = 7'h2a;
            4'd9:    c = 7'h37;
            4'd10:   c = 7'h34;
            4'd11:   c = 7'h31;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ src/kpd_scan_fsm.sv @@
// ----------------------------------------------------------------------------
// kpd_scan_fsm
// scan state machine: one tick per accepted request, result computed alongside
// ----------------------------------------------------------------------------
module kpd_scan_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [kpd_pkg::RowWidth-1:0]        row_pins,
    input  logic [kpd_pkg::CountWidth-1:0]      debounce_ticks,
    output kpd_pkg::kpd_result_t                result
);

    kpd_pkg::kpd_state_t                   state_reg, state_next;
    logic [kpd_pkg::CountWidth-1:0]        count_reg, count_next;
    logic [kpd_pkg::ColWidth-1:0]          drive_reg, drive_next;
    logic [kpd_pkg::CountWidth-1:0]        count_inc;
    logic [1:0]                            col;
    kpd_pkg::kpd_row_t                     dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kpd_pkg::ST_WAIT;
            count_reg <= '0;
            drive_reg <= kpd_pkg::AllColumns;
        end
        else if (step)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drive_reg <= drive_next;
        end
    end

    always_comb
    begin
        dec        = kpd_pkg::decode_row(row_pins);
        state_next = state_reg;
        count_next = count_reg;
        drive_next = drive_reg;
        col        = 2'd0;
        count_inc  = (count_reg < debounce_ticks) ? count_reg + 8'd1 : count_reg;
        result.key_valid = 1'b0;
        result.key_char  = '0;

        case (state_reg)
            kpd_pkg::ST_DEBOUNCE:
            begin
                if (dec.pressed)
                begin
                    count_next = count_inc;
                    if (count_inc >= debounce_ticks)
                    begin
                        state_next = kpd_pkg::ST_CHECK0;
                        drive_next = kpd_pkg::Column0;
                    end
                end
            end
            kpd_pkg::ST_CHECK0, kpd_pkg::ST_CHECK1, kpd_pkg::ST_CHECK2:
            begin
                col = (state_reg == kpd_pkg::ST_CHECK0) ? 2'd0 :
                      (state_reg == kpd_pkg::ST_CHECK1) ? 2'd1 : 2'd2;
                if (dec.pressed)
                begin
                    state_next       = kpd_pkg::ST_RELEASE;
                    result.key_valid = 1'b1;
                    result.key_char  = kpd_pkg::key_lookup({col, dec.row});
                end
                else if (state_reg == kpd_pkg::ST_CHECK0)
                begin
                    state_next = kpd_pkg::ST_CHECK1;
                    drive_next = kpd_pkg::Column1;
                end
                else if (state_reg == kpd_pkg::ST_CHECK1)
                begin
                    state_next = kpd_pkg::ST_CHECK2;
                    drive_next = kpd_pkg::Column2;
                end
                else
                begin
                    // column 2 stays driven until the next wait tick
                    state_next = kpd_pkg::ST_WAIT;
                end
            end
            kpd_pkg::ST_RELEASE:
            begin
                if (!dec.pressed)
                    state_next = kpd_pkg::ST_WAIT;
            end
            default:
            begin
                drive_next = kpd_pkg::AllColumns;
                if (dec.pressed)
                begin
                    state_next = kpd_pkg::ST_DEBOUNCE;
                    count_next = '0;
                end
                else
                    state_next = kpd_pkg::ST_WAIT;
            end
        endcase

        result.column_drive = drive_next;
    end

endmodule

@@ src/keypad_scan_debounce_core.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_debounce_core
// 3 column by 4 row keypad scanner with debounce, one scan tick per request
// ----------------------------------------------------------------------------
// each input request is one scan tick carrying the four active-low row pin
// levels; it produces exactly one result request (key_valid, key_char,
// column_drive). a request can be taken every clock cycle while s_tready is
// high: the scan state is updated in the cycle of acceptance and the result
// is registered into the output register that drives the master side. a
// second (skid) slot behind the output register takes the result instead,
// and lets the slave side take one more request, while the master side is
// stalled; s_tready drops only when both slots are full. the debounce limit
// comes from the cfg write channel (reset value 100), which is always ready
// and should be written only while the scanner is idle
// ----------------------------------------------------------------------------
module keypad_scan_debounce_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // scan tick requests
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [8*kpd_pkg::InBytes-1:0]         s_tdata,   // [3:0] row_pins
    // result requests
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [8*kpd_pkg::OutBytes-1:0]        m_tdata,   // [0] key_valid,
                                                             // [7:1] key_char,
                                                             // [10:8] column_drive
    // debounce limit write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kpd_pkg::CountWidth-1:0]        cfg_data
);

    logic [kpd_pkg::CountWidth-1:0] ticks_reg;
    kpd_pkg::kpd_result_t           new_result;
    kpd_pkg::kpd_result_t           out_reg;
    kpd_pkg::kpd_result_t           skid_reg;
    logic                           out_valid_reg;
    logic                           skid_valid_reg;
    logic                           accept;
    logic                           out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // debounce limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ticks_reg <= kpd_pkg::DebounceInit;
        else if (cfg_valid && cfg_ready)
            ticks_reg <= cfg_data;
    end

    // scan state and per-tick result
    kpd_scan_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .row_pins       (s_tdata[kpd_pkg::RowWidth-1:0]),
        .debounce_ticks (ticks_reg),
        .result         (new_result)
    );

    // output register with skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid is always empty when a new request is accepted
            out_valid_reg  <= accept || skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : new_result;
        else if (accept)
            skid_reg <= new_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8*kpd_pkg::OutBytes - $bits(kpd_pkg::kpd_result_t)){1'b0}}, out_reg};

`ifndef ASSERT_OFF
    // skid slot is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

    // a reported key always comes with a single column driven
    a_hit_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.key_valid) |-> $onehot(out_reg.column_drive))
        else $error("key reported without a single driven column");

    // no character without a hit, and a hit always has a character
    a_char_with_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.key_valid == (out_reg.key_char != '0)))
        else $error("key character and key valid disagree");

    // a stalled result with a full skid slot blocks new requests
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> !s_tready)
        else $error("request accepted with both slots full");
`endif

endmodule

@@ dv/tb_keypad_scan_debounce_core.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_scan_debounce_core
// self-checking bench for the keypad scanner: scan tick requests go in on the
// slave stream, and an in-bench scanner predicts each result request, which
// is compared field by field with what comes out of the master stream
// ----------------------------------------------------------------------------
module tb_keypad_scan_debounce_core;

    timeunit 1ns;
    timeprecision 1ps;

    import kpd_pkg::*;

    // key at index 4*column+row
    localparam string KeyMap = "#9630852*741";

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [3:0] row_pins
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [0] key_valid, [7:1] key_char, [10:8] column_drive
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    keypad_scan_debounce_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // scanner state as the bench sees it
    kpd_state_t           sc_state = ST_WAIT;
    logic [7:0]           sc_count = '0;
    logic [ColWidth-1:0]  sc_drive = AllColumns;
    logic [7:0]           sc_limit = DebounceInit;

    logic [3:0]   row_ticks_pending [$];   // scan ticks not yet offered
    logic [3:0]   tick_seq [$];            // scratch for building one sequence
    kpd_result_t  key_results_due [$];     // predicted result requests, oldest first

    bit  no_idle   = 1'b0;   // both sides run flat out when set
    bit  hold_req  = 1'b0;   // asks the receiver for one long hold-off
    int  fail_count   = 0;
    int  results_seen = 0;
    int  send_gap  = 0;
    int  stall_left = 0;
    bit  hold_done = 1'b0;

    function automatic bit is_press(input logic [3:0] pins);
        return pins == RowCode0 || pins == RowCode1 || pins == RowCode2 || pins == RowCode3;
    endfunction

    function automatic logic [3:0] row_code(input int r);
        case (r)
            0:       return RowCode0;
            1:       return RowCode1;
            2:       return RowCode2;
            default: return RowCode3;
        endcase
    endfunction

    // mostly all rows high, sometimes another pattern that is not a single row
    function automatic logic [3:0] idle_pins();
        logic [3:0] p;
        p = 4'hf;
        if ($urandom_range(0, 3) == 0)
        begin
            p = 4'($urandom_range(0, 15));
            while (is_press(p))
                p = 4'($urandom_range(0, 15));
        end
        return p;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // advances the bench scanner by one tick and gives the result it produces
    function automatic kpd_result_t scan_tick_result(input logic [3:0] pins);
        kpd_result_t res;
        logic        hit;
        logic [1:0]  row;
        int unsigned col;
        res = '0;
        hit = 1'b1;
        row = 2'd0;
        if (pins == RowCode0)
            row = 2'd0;
        else if (pins == RowCode1)
            row = 2'd1;
        else if (pins == RowCode2)
            row = 2'd2;
        else if (pins == RowCode3)
            row = 2'd3;
        else
            hit = 1'b0;

        case (sc_state)
            ST_DEBOUNCE:
                if (hit)
                begin
                    // a bounce leaves the count alone, only presses move it
                    if (sc_count < sc_limit)
                        sc_count = sc_count + 8'd1;
                    if (sc_count >= sc_limit)
                    begin
                        sc_state = ST_CHECK0;
                        sc_drive = Column0;
                    end
                end
            ST_CHECK0, ST_CHECK1, ST_CHECK2:
            begin
                col = sc_state - ST_CHECK0;
                if (hit)
                begin
                    sc_state          = ST_RELEASE;
                    res.key_valid     = 1'b1;
                    res.key_char      = 7'(KeyMap[4 * col + row]);
                end
                else if (col < 2)
                begin
                    sc_state = kpd_state_t'(sc_state + 1);
                    sc_drive = ColWidth'(1 << (col + 1));
                end
                else
                    sc_state = ST_WAIT;   // last column stays driven for this tick
            end
            ST_RELEASE:
                if (!hit)
                    sc_state = ST_WAIT;
            default:
            begin
                sc_drive = AllColumns;
                if (hit)
                begin
                    sc_state = ST_DEBOUNCE;
                    sc_count = '0;
                end
                else
                    sc_state = ST_WAIT;
            end
        endcase
        res.column_drive = sc_drive;
        return res;
    endfunction

    // sender: offers pending scan ticks and predicts on every accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                key_results_due.push_back(scan_tick_result(s_tdata[3:0]));

            if (s_tvalid && !s_tready)
                ;   // request held until taken
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (row_ticks_pending.size() > 0)
            begin
                s_tdata  <= {4'b0, row_ticks_pending.pop_front()};
                s_tvalid <= 1'b1;
                send_gap = no_idle ? 0 : pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off so the skid slot fills
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (hold_req && !hold_done)
            begin
                stall_left = 300;
                hold_done  = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle)
                    stall_left = pick_gap();
            end
        end
    end

    // checker: each result request against the oldest prediction
    always @(posedge clk)
    begin
        kpd_result_t got;
        kpd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got = m_tdata[10:0];
            if (key_results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result valid %0b char %h drive %b",
                             $realtime, got.key_valid, got.key_char, got.column_drive);
            end
            else
            begin
                want = key_results_due.pop_front();
                if (got.key_valid !== want.key_valid || got.key_char !== want.key_char
                    || got.column_drive !== want.column_drive)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result %0d expected %0b/%h/%b, got %0b/%h/%b",
                                 $realtime, results_seen, want.key_valid, want.key_char,
                                 want.column_drive, got.key_valid, got.key_char,
                                 got.column_drive);
                end
            end
        end
    end

    // waits until every request went through and the output has drained
    task automatic settle();
        while (row_ticks_pending.size() != 0 || s_tvalid || key_results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sc_limit = v;
        cfg_valid <= 1'b0;
    endtask

    // one key press as a real pad shows it: press, debounce with bounces,
    // the row shows low only while its own column is driven, hold, release
    task automatic build_press(input int lim);
        int r;
        int c;
        int need;
        tick_seq.delete();
        r = $urandom_range(0, 3);
        c = $urandom_range(0, 3);   // 3: key let go before any column matched
        repeat ($urandom_range(0, 3))
            tick_seq.push_back(idle_pins());
        tick_seq.push_back(row_code(r));
        need = (lim == 0) ? 1 : lim;
        while (need > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                tick_seq.push_back(idle_pins());
            else
            begin
                tick_seq.push_back(row_code(r));
                need--;
            end
        end
        for (int k = 0; k < c && k < 3; k++)
            tick_seq.push_back(idle_pins());
        if (c < 3)
        begin
            tick_seq.push_back(row_code(r));
            repeat ($urandom_range(0, 4))
                tick_seq.push_back(row_code($urandom_range(0, 3)));
            tick_seq.push_back(idle_pins());
        end
    endtask

    // presses long enough to get through debounce from anywhere, then
    // enough idle ticks to land back in wait
    task automatic append_flush(input int lim);
        repeat (((lim == 0) ? 1 : lim) + 1)
            tick_seq.push_back(row_code($urandom_range(0, 3)));
        repeat (4)
            tick_seq.push_back(idle_pins());
    endtask

    task automatic fill_phase(input int lim, input int n);
        int pushed;
        int kind;
        int cut;
        pushed = 0;
        while (pushed < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                build_press(lim);
            else if (kind == 7)
            begin
                // broken press: cut short somewhere
                build_press(lim);
                cut = $urandom_range(1, tick_seq.size() - 1);
                while (tick_seq.size() > cut)
                    void'(tick_seq.pop_back());
                append_flush(lim);
            end
            else
            begin
                // raw noise on the row pins
                tick_seq.delete();
                repeat ($urandom_range(1, 8))
                    tick_seq.push_back(4'($urandom_range(0, 15)));
                append_flush(lim);
            end
            foreach (tick_seq[i])
                row_ticks_pending.push_back(tick_seq[i]);
            pushed += tick_seq.size();
        end
    endtask

    task automatic run_phase(input int lim, input int n, input bit fast, input bit squeeze);
        settle();
        write_limit(8'(lim));
        no_idle = fast;
        fill_phase(lim, n);
        if (squeeze)
            hold_req = 1'b1;
    endtask

    task automatic push_ticks(input logic [3:0] ticks []);
        foreach (ticks[i])
            row_ticks_pending.push_back(ticks[i]);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: idle, all rows low (no press), press, bounces, two
        // counted presses; stays in debounce well short of the limit
        push_ticks('{4'hf, 4'h0, 4'he, 4'hf, 4'hd, 4'h3, 4'hd});
        settle();

        // limit lowered below the count: next press starts the column check,
        // the key sits in column 1 row 2, then held and let go
        write_limit(8'd1);
        push_ticks('{4'h7, 4'hf, 4'hb, 4'hb, 4'hf});
        settle();

        // zero limit: checking starts on the first pressed debounce tick;
        // column 0 hit, a press that no column claims, column 2 row 3 hit
        write_limit(8'd0);
        push_ticks('{4'he, 4'he, 4'he, 4'hf,
                     4'h7, 4'h7, 4'hf, 4'hf, 4'hf,
                     4'hd, 4'hd, 4'hf, 4'hf, 4'h7, 4'hf});

        run_phase(1, 120, 1'b0, 1'b0);
        run_phase(3, 120, 1'b1, 1'b1);
        run_phase(255, 50, 1'b0, 1'b0);
        run_phase(2, 120, 1'b0, 1'b0);
        run_phase(100, 80, 1'b1, 1'b0);
        run_phase($urandom_range(1, 12), 120, 1'b0, 1'b0);
        settle();

        if (fail_count == 0)
            $display("keypad_scan_debounce_core test passed");
        else
            $display("keypad_scan_debounce_core test failed");
        $finish;
    end

    initial
    begin
        #600000;
        $display("keypad_scan_debounce_core test failed");
        $finish;
    end

endmodule

@@ keypad_scan_debounce_core.f @@
src/kpd_pkg.sv
src/kpd_scan_fsm.sv
src/keypad_scan_debounce_core.sv
dv/tb_keypad_scan_debounce_core.sv
